/* rtl/lspk_pkg.sv */
// Shared types, constants and helpers for the LED sparkle frame engine.
package lspk_pkg;

  localparam int MAX_LEDS     = 64;
  localparam int LED_IDX_W    = $clog2(MAX_LEDS);
  localparam int LED_CNT_W    = LED_IDX_W + 1;
  localparam int TRAIL_LENGTH = 6;
  localparam int TRAIL_W      = 3;
  localparam int POS_W        = 9;

  localparam logic [7:0] STAR_SAT   = 8'd150;
  localparam logic [7:0] STAR_HEAD  = 8'd255;
  localparam logic [7:0] STAR_DECAY = 8'd45;

  localparam logic signed [POS_W-1:0] STAR_MARGIN = 9'sd5;
  localparam logic signed [POS_W-1:0] STAR_STEP   = 9'sd2;

  localparam logic [6:0]  RST_LED_COUNT    = 7'd32;
  localparam logic [9:0]  RST_FRAME_PERIOD = 10'd25;
  localparam logic [7:0]  RST_FADE_IN      = 8'd20;
  localparam logic [7:0]  RST_FADE_OUT     = 8'd8;
  localparam logic [6:0]  RST_TWINKLE_PCT  = 7'd15;
  localparam logic [6:0]  RST_STAR_PCT     = 7'd5;
  localparam logic [15:0] RST_STAR_COOL    = 16'd3000;
  localparam logic [7:0]  RST_TWINKLE_SAT  = 8'd180;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    REG_LED_COUNT    = 3'd0,
    REG_FRAME_PERIOD = 3'd1,
    REG_FADE_IN      = 3'd2,
    REG_FADE_OUT     = 3'd3,
    REG_TWINKLE_PCT  = 3'd4,
    REG_STAR_PCT     = 3'd5,
    REG_STAR_COOL    = 3'd6,
    REG_TWINKLE_SAT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK
  } state_t;

  // One LED's stored state.
  typedef struct packed {
    logic [7:0] level;
    logic [7:0] target;
    logic [7:0] hue;
  } led_entry_t;

  // Per-frame context handed to the pixel update.
  typedef struct packed {
    logic                 arm;
    logic [LED_IDX_W-1:0] spawn_led;
    logic [7:0]           spawn_level;
    logic [7:0]           spawn_hue;
    logic [7:0]           fade_in;
    logic [7:0]           fade_out;
    logic [7:0]           twinkle_sat;
    logic                 star_on;
    pos_t                 star_pos;
    logic                 star_down;
    logic [7:0]           star_hue;
  } frame_ctx_t;

  function automatic logic [7:0] trail_value(input logic [TRAIL_W-1:0] t);
    logic [15:0] drop;
    drop = 16'(STAR_DECAY) * 16'(t);
    return STAR_HEAD - drop[7:0];
  endfunction

endpackage

/* rtl/lspk_store.sv */
// LED state memory: level, target and hue per LED, registered read, data valid the cycle after rd_en.
module lspk_store import lspk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [LED_IDX_W-1:0] rd_addr,
  output led_entry_t           rd_data,
  input  logic                 wr_en,
  input  logic [LED_IDX_W-1:0] wr_addr,
  input  led_entry_t           wr_data
);

  led_entry_t          mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] written;
  led_entry_t          rdata;
  logic                rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= written[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : '0;

endmodule

/* rtl/lspk_pixel.sv */
// Per-LED update: twinkle arm, fade toward target, star trail overlay.
module lspk_pixel import lspk_pkg::*; (
  input  led_entry_t           cur,
  input  logic [LED_IDX_W-1:0] idx,
  input  frame_ctx_t           ctx,
  output led_entry_t           upd,
  output logic [7:0]           hue,
  output logic [7:0]           sat,
  output logic [7:0]           val
);

  logic [7:0] lv, tg, hu, lv_n, tg_n;
  logic [8:0] sum;
  pos_t       idx_pos, t;
  logic       hit;

  always_comb begin
    lv = cur.level;
    tg = cur.target;
    hu = cur.hue;
    if (ctx.arm && idx == ctx.spawn_led && tg == 8'd0) begin
      tg = ctx.spawn_level;
      hu = ctx.spawn_hue;
    end

    sum = {1'b0, lv} + {1'b0, ctx.fade_in};
    if (lv < tg) begin
      lv_n = (sum > {1'b0, tg}) ? tg : sum[7:0];
    end else if (lv > tg) begin
      lv_n = (lv > ctx.fade_out) ? lv - ctx.fade_out : 8'd0;
    end else begin
      lv_n = lv;
    end
    tg_n = (lv_n >= tg && tg != 8'd0) ? 8'd0 : tg;

    upd.level  = lv_n;
    upd.target = tg_n;
    upd.hue    = hu;

    idx_pos = pos_t'({{(POS_W-LED_IDX_W){1'b0}}, idx});
    t   = ctx.star_down ? (idx_pos - ctx.star_pos) : (ctx.star_pos - idx_pos);
    hit = ctx.star_on && !t[POS_W-1] && (t < pos_t'(TRAIL_LENGTH));

    if (hit) begin
      hue = ctx.star_hue;
      sat = STAR_SAT;
      val = trail_value(t[TRAIL_W-1:0]);
    end else if (lv_n != 8'd0) begin
      hue = hu;
      sat = ctx.twinkle_sat;
      val = lv_n;
    end else begin
      hue = 8'd0;
      sat = 8'd0;
      val = 8'd0;
    end
  end

endmodule

/* rtl/led_sparkle_frame_engine_core.sv */
// LED sparkle frame engine: timestamp in, one HSV pixel per LED in use out per rendered frame.
// Flow: ST_IDLE takes an item, ST_CHECK decides on a frame, and ST_WALK reads each
// LED through the single read port of the LED state memory into the output register;
// a frame of n LEDs streams one pixel per cycle while out_ready stays high. Without a
// frame ST_CHECK returns to ST_IDLE, the only state that takes a new item. Reset
// clears control state at once; LED state reads as zero until written, no clearing pass.
module led_sparkle_frame_engine_core import lspk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          now_ms,
  input  logic [6:0]           spawn_roll,
  input  logic [5:0]           spawn_led,
  input  logic [7:0]           spawn_level,
  input  logic [7:0]           spawn_hue,
  input  logic [6:0]           star_roll,
  input  logic                 star_side,
  input  logic [7:0]           star_hue_draw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           led_index,
  output logic [7:0]           pixel_hue,
  output logic [7:0]           pixel_saturation,
  output logic [7:0]           pixel_value,
  output logic                 last_pixel
);

  // configuration
  logic [6:0]  led_count;
  logic [9:0]  frame_period_ms;
  logic [7:0]  fade_in_step, fade_out_step;
  logic [6:0]  twinkle_chance, star_chance;
  logic [15:0] star_cooldown_ms;
  logic [7:0]  twinkle_saturation;

  // captured item
  logic [31:0]          now_r;
  logic [6:0]           spawn_roll_r, star_roll_r;
  logic [LED_IDX_W-1:0] spawn_led_r;
  logic [7:0]           spawn_level_r, spawn_hue_r, star_hue_r;
  logic                 star_side_r;

  // persistent star and timing state
  logic        star_active, star_moves_down;
  pos_t        star_position;
  logic [7:0]  star_hue;
  logic [31:0] last_frame_ms, last_star_ms;

  state_t     state, state_next;
  frame_ctx_t ctx;

  logic [LED_CNT_W-1:0] n;
  logic [LED_IDX_W-1:0] last_idx;
  logic [LED_CNT_W-1:0] issue_idx;
  logic [LED_IDX_W-1:0] rd_idx;
  logic                 rd_pend;
  logic                 issue, consume, want;

  logic [31:0] frame_gap, star_gap;
  logic        frame_go, star_go;
  pos_t        start_pos, cur_pos, moved_pos, end_pos;
  logic        cur_down, cur_active;
  logic [7:0]  cur_hue;

  led_entry_t rd_data, upd;
  logic [7:0] px_hue, px_sat, px_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count          <= RST_LED_COUNT;
      frame_period_ms    <= RST_FRAME_PERIOD;
      fade_in_step       <= RST_FADE_IN;
      fade_out_step      <= RST_FADE_OUT;
      twinkle_chance     <= RST_TWINKLE_PCT;
      star_chance        <= RST_STAR_PCT;
      star_cooldown_ms   <= RST_STAR_COOL;
      twinkle_saturation <= RST_TWINKLE_SAT;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LED_COUNT:    led_count          <= cfg_data[6:0];
        REG_FRAME_PERIOD: frame_period_ms    <= cfg_data[9:0];
        REG_FADE_IN:      fade_in_step       <= cfg_data[7:0];
        REG_FADE_OUT:     fade_out_step      <= cfg_data[7:0];
        REG_TWINKLE_PCT:  twinkle_chance     <= cfg_data[6:0];
        REG_STAR_PCT:     star_chance        <= cfg_data[6:0];
        REG_STAR_COOL:    star_cooldown_ms   <= cfg_data;
        REG_TWINKLE_SAT:  twinkle_saturation <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // LEDs in use, clamped to 1..MAX_LEDS
  always_comb begin
    if (led_count == '0) begin
      n = LED_CNT_W'(1);
    end else if (led_count > LED_CNT_W'(MAX_LEDS)) begin
      n = LED_CNT_W'(MAX_LEDS);
    end else begin
      n = led_count;
    end
    last_idx = LED_IDX_W'(n - LED_CNT_W'(1));
  end

  // frame and star decisions
  always_comb begin
    frame_gap  = now_r - last_frame_ms;
    star_gap   = now_r - last_star_ms;
    frame_go   = frame_gap >= {22'd0, frame_period_ms};
    star_go    = !star_active && (star_gap > {16'd0, star_cooldown_ms}) &&
                 (star_roll_r < star_chance);
    start_pos  = star_side_r ? pos_t'({{(POS_W-LED_IDX_W){1'b0}}, last_idx}) : '0;
    cur_pos    = star_go ? start_pos : star_position;
    cur_down   = star_go ? (start_pos != '0) : star_moves_down;
    cur_active = star_active || star_go;
    cur_hue    = star_go ? star_hue_r : star_hue;
    moved_pos  = cur_down ? (cur_pos - STAR_STEP) : (cur_pos + STAR_STEP);
    end_pos    = pos_t'({{(POS_W-LED_CNT_W){1'b0}}, n}) + STAR_MARGIN;
  end

  // walk handshake: one memory read in flight, drained into the output register
  assign want    = (state == ST_WALK) && (issue_idx < n);
  assign consume = rd_pend && (!out_valid || out_ready);
  assign issue   = want && (!rd_pend || consume);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = frame_go ? ST_WALK : ST_IDLE;
      ST_WALK:  if (consume && rd_idx == last_idx) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r         <= now_ms;
      spawn_roll_r  <= spawn_roll;
      spawn_led_r   <= spawn_led;
      spawn_level_r <= spawn_level;
      spawn_hue_r   <= spawn_hue;
      star_roll_r   <= star_roll;
      star_side_r   <= star_side;
      star_hue_r    <= star_hue_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star_active     <= 1'b0;
      star_moves_down <= 1'b0;
      star_position   <= '0;
      star_hue        <= 8'd0;
      last_frame_ms   <= 32'd0;
      last_star_ms    <= 32'd0;
      ctx             <= '0;
    end else if (state == ST_CHECK && frame_go) begin
      last_frame_ms   <= now_r;
      ctx.arm         <= spawn_roll_r < twinkle_chance;
      ctx.spawn_led   <= spawn_led_r;
      ctx.spawn_level <= spawn_level_r;
      ctx.spawn_hue   <= spawn_hue_r;
      ctx.fade_in     <= fade_in_step;
      ctx.fade_out    <= fade_out_step;
      ctx.twinkle_sat <= twinkle_saturation;
      ctx.star_on     <= cur_active;
      ctx.star_pos    <= cur_pos;
      ctx.star_down   <= cur_down;
      ctx.star_hue    <= cur_hue;
      if (star_go) begin
        last_star_ms <= now_r;
      end
      // the star moves after this frame's trail is drawn
      if (cur_active) begin
        star_position   <= moved_pos;
        star_moves_down <= cur_down;
        star_hue        <= cur_hue;
        star_active     <= !((moved_pos < -STAR_MARGIN) || (moved_pos >= end_pos));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      rd_idx    <= '0;
    end else if (state == ST_CHECK) begin
      issue_idx <= '0;
      rd_pend   <= 1'b0;
    end else if (issue) begin
      issue_idx <= issue_idx + LED_CNT_W'(1);
      rd_idx    <= issue_idx[LED_IDX_W-1:0];
      rd_pend   <= 1'b1;
    end else if (consume) begin
      rd_pend <= 1'b0;
    end
  end

  lspk_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (issue_idx[LED_IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (consume),
    .wr_addr (rd_idx),
    .wr_data (upd)
  );

  lspk_pixel u_pixel (
    .cur (rd_data),
    .idx (rd_idx),
    .ctx (ctx),
    .upd (upd),
    .hue (px_hue),
    .sat (px_sat),
    .val (px_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      led_index        <= rd_idx;
      pixel_hue        <= px_hue;
      pixel_saturation <= px_sat;
      pixel_value      <= px_val;
      last_pixel       <= (rd_idx == last_idx);
    end
  end

endmodule
